/* rtl/u8chk_pkg.sv */
// Shared types and constants for the UTF-8 text check decoder.
`timescale 1ns / 1ps

package u8chk_pkg;

	// Kinds of byte as seen without regard to decoder state.
	typedef enum logic [1:0] {
		KIND_TEXT,
		KIND_BAD,
		KIND_CONT,
		KIND_LEAD
	} kind_t;

	// One classified byte as it travels from the front part to the back part.
	typedef struct packed {
		logic       last;
		kind_t      kind;
		logic [2:0] pend;
		logic [6:0] bits;
	} class_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CHAR_COUNT_W = 16;
	localparam int CODE_POINT_W = 31;

endpackage

/* rtl/utf8_text_check_decoder.sv */
// Top level of the UTF-8 text check decoder.
//
//   Channel  Handshake               Payload
//   input    in_valid / in_ready     data_byte, last_byte
//   output   out_valid / out_ready   char_ready, code_point, char_count,
//                                    verdict_ready, is_utf8
//
// One byte per clock cycle is sustained while out_ready stays high. A byte that is
// transferred is written into the front queue and is then moved into the output
// register, from which its result is offered until it is transferred.
// The throughput is set by the state update in the back part.
// arst_n clears the queue pointers, the sequence state and the output valid flag at once.
// A stalled output fills the four-entry queue, after which in_ready falls.
`timescale 1ns / 1ps

module utf8_text_check_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        char_ready,
	output logic [30:0] code_point,
	output logic [15:0] char_count,
	output logic        verdict_ready,
	output logic        is_utf8
);

	logic              q_full;
	logic              q_not_empty;
	logic              push;
	logic              pop;
	u8chk_pkg::class_t push_item;
	u8chk_pkg::class_t head;

	u8chk_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	u8chk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	u8chk_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_ready    (char_ready),
		.code_point    (code_point),
		.char_count    (char_count),
		.verdict_ready (verdict_ready),
		.is_utf8       (is_utf8)
	);

endmodule

/* rtl/u8chk_front.sv */
// Front part: takes bytes in and classifies them for the queue.
`timescale 1ns / 1ps

module u8chk_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              push,
	output u8chk_pkg::class_t push_item
);

	logic is_text;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		is_text = (data_byte >= 8'h20 && data_byte <= 8'h7E) ||
			data_byte == 8'h07 || data_byte == 8'h08 || data_byte == 8'h09 ||
			data_byte == 8'h0A || data_byte == 8'h0C || data_byte == 8'h0D ||
			data_byte == 8'h1B;

		push_item.last = last_byte;
		push_item.pend = 3'd0;
		push_item.bits = 7'd0;
		push_item.kind = u8chk_pkg::KIND_BAD;

		if (!data_byte[7]) begin
			if (is_text) begin
				push_item.kind = u8chk_pkg::KIND_TEXT;
				push_item.bits = data_byte[6:0];
			end
		end else if (!data_byte[6]) begin
			push_item.kind = u8chk_pkg::KIND_CONT;
			push_item.bits = {1'b0, data_byte[5:0]};
		end else if (!data_byte[5]) begin
			push_item.kind = u8chk_pkg::KIND_LEAD;
			push_item.pend = 3'd1;
			push_item.bits = {2'b0, data_byte[4:0]};
		end else if (!data_byte[4]) begin
			push_item.kind = u8chk_pkg::KIND_LEAD;
			push_item.pend = 3'd2;
			push_item.bits = {3'b0, data_byte[3:0]};
		end else if (!data_byte[3]) begin
			push_item.kind = u8chk_pkg::KIND_LEAD;
			push_item.pend = 3'd3;
			push_item.bits = {4'b0, data_byte[2:0]};
		end else if (!data_byte[2]) begin
			push_item.kind = u8chk_pkg::KIND_LEAD;
			push_item.pend = 3'd4;
			push_item.bits = {5'b0, data_byte[1:0]};
		end else if (!data_byte[1]) begin
			push_item.kind = u8chk_pkg::KIND_LEAD;
			push_item.pend = 3'd5;
			push_item.bits = {6'b0, data_byte[0]};
		end
		// 0xFE and 0xFF stay as bad bytes.
	end

endmodule

/* rtl/u8chk_queue.sv */
// Short queue of classified bytes between the front and back parts.
`timescale 1ns / 1ps

module u8chk_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8chk_pkg::class_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output u8chk_pkg::class_t head
);

	u8chk_pkg::class_t                  slots_q [u8chk_pkg::QUEUE_DEPTH];
	logic [u8chk_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [u8chk_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [u8chk_pkg::QCNT_W-1:0]       count_q;

	assign full      = count_q == u8chk_pkg::QCNT_W'(u8chk_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= u8chk_pkg::QCNT_W'(u8chk_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

endmodule

/* rtl/u8chk_back.sv */
// Back part: sequence state, decoding and the output register.
`timescale 1ns / 1ps

module u8chk_back #(
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  u8chk_pkg::class_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              char_ready,
	output logic [30:0]       code_point,
	output logic [15:0]       char_count,
	output logic              verdict_ready,
	output logic              is_utf8
);

	localparam int EXT_W = (COUNT_BITS > u8chk_pkg::CHAR_COUNT_W) ?
		COUNT_BITS : u8chk_pkg::CHAR_COUNT_W;

	logic [2:0]            pend_q;
	logic [30:0]           pv_q;
	logic                  seen_q;
	logic                  rej_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [2:0]            pend_d;
	logic [30:0]           pv_d;
	logic                  seen_d;
	logic                  rej_d;
	logic [COUNT_BITS-1:0] count_d;
	logic                  ready_d;
	logic [30:0]           cp_d;
	logic [30:0]           shifted;
	logic [EXT_W-1:0]      count_ext;

	logic                  out_valid_q;
	logic                  char_ready_q;
	logic [30:0]           code_point_q;
	logic [15:0]           char_count_q;
	logic                  verdict_q;
	logic                  is_utf8_q;

	// The next byte moves in whenever the output register is free or being emptied.
	assign pop = q_not_empty && (!out_valid_q || out_ready);

	assign shifted   = {pv_q[24:0], head.bits[5:0]};
	assign count_ext = EXT_W'(count_d);

	always_comb begin
		pend_d  = pend_q;
		pv_d    = pv_q;
		seen_d  = seen_q;
		rej_d   = rej_q;
		count_d = count_q;
		ready_d = 1'b0;
		cp_d    = '0;

		if (!rej_q) begin
			if (pend_q != 3'd0) begin
				if (head.kind != u8chk_pkg::KIND_CONT) begin
					rej_d = 1'b1;
				end else begin
					pend_d = pend_q - 3'd1;
					pv_d   = shifted;
					if (pend_q == 3'd1) begin
						ready_d = 1'b1;
						cp_d    = shifted;
						pv_d    = '0;
						seen_d  = 1'b1;
					end
				end
			end else begin
				case (head.kind)
					u8chk_pkg::KIND_TEXT: begin
						ready_d = 1'b1;
						cp_d    = {24'd0, head.bits};
					end
					u8chk_pkg::KIND_LEAD: begin
						pend_d = head.pend;
						pv_d   = {24'd0, head.bits};
					end
					default: begin
						rej_d = 1'b1;
					end
				endcase
			end
			if (ready_d && count_q != '1) begin
				count_d = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			pv_q    <= '0;
			seen_q  <= 1'b0;
			rej_q   <= 1'b0;
			count_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				pend_q  <= '0;
				pv_q    <= '0;
				seen_q  <= 1'b0;
				rej_q   <= 1'b0;
				count_q <= '0;
			end else begin
				pend_q  <= pend_d;
				pv_q    <= pv_d;
				seen_q  <= seen_d;
				rej_q   <= rej_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			char_ready_q <= ready_d;
			code_point_q <= cp_d;
			char_count_q <= count_ext[15:0];
			verdict_q    <= head.last;
			is_utf8_q    <= head.last && !rej_d && seen_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign char_ready    = char_ready_q;
	assign code_point    = code_point_q;
	assign char_count    = char_count_q;
	assign verdict_ready = verdict_q;
	assign is_utf8       = is_utf8_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> (pend_q == 3'd0 && count_q == '0 && !rej_q && !seen_q))
		else $error("state not cleared after the last byte of a buffer");

	a_verdict_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_utf8_q) |-> verdict_q)
		else $error("verdict given on a byte that is not the last");

	a_cp_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !char_ready_q) |-> (code_point_q == '0))
		else $error("code point set without a completed character");

	a_rej_no_pending_work: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && rej_q) |-> (!ready_d && pend_d == pend_q))
		else $error("rejected buffer still decoding");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the UTF-8 text check decoder.
`timescale 1ns / 1ps

module testbench;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic                               char_ready;
		logic [u8chk_pkg::CODE_POINT_W-1:0] code_point;
		logic [u8chk_pkg::CHAR_COUNT_W-1:0] char_count;
		logic                               verdict_ready;
		logic                               is_utf8;
	} decode_result_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;

	// Byte values used by the directed sequences.
	localparam logic [7:0] LEAD_INVALID_FE = 8'hFE;
	localparam logic [7:0] LEAD_INVALID_FF = 8'hFF;
	localparam logic [7:0] LEAD_SIX_BYTE   = 8'hFD;
	localparam logic [7:0] CONT_ALL_ONES   = 8'hBF;
	localparam logic [7:0] CONT_ALL_ZEROS  = 8'h80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        char_ready;
	logic [30:0] code_point;
	logic [15:0] char_count;
	logic        verdict_ready;
	logic        is_utf8;

	// Predictor state, cleared after the final byte of every buffer.
	logic [2:0]                         cont_left = '0;
	logic [u8chk_pkg::CODE_POINT_W-1:0] partial_cp = '0;
	logic                               seen_multi = 1'b0;
	logic                               buf_rejected = 1'b0;
	logic [u8chk_pkg::CHAR_COUNT_W-1:0] chars_in_buf = '0;

	decode_result_t expected_results[$];
	int mismatches = 0;
	int bytes_sent = 0;
	int sender_gap_pct = 0;
	int receiver_stall_pct = 0;
	bit hold_off_request = 1'b0;
	int idle_cycles = 0;

	utf8_text_check_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_ready   (char_ready),
		.code_point   (code_point),
		.char_count   (char_count),
		.verdict_ready(verdict_ready),
		.is_utf8      (is_utf8)
	);

	always #5 clk = ~clk;

	function automatic bit is_plain_text(input logic [7:0] b);
		return (b >= 8'h20 && b <= 8'h7E) || b == 8'h07 || b == 8'h08 || b == 8'h09 ||
			b == 8'h0A || b == 8'h0C || b == 8'h0D || b == 8'h1B;
	endfunction

	// Works out the result for one byte and advances the predictor state.
	function automatic decode_result_t decode_byte(input logic [7:0] b, input logic fin);
		decode_result_t r;
		r = '0;
		if (!buf_rejected) begin
			if (cont_left != 0) begin
				if (b[7:6] != 2'b10) begin
					buf_rejected = 1'b1;
				end else begin
					partial_cp = {partial_cp[u8chk_pkg::CODE_POINT_W-7:0], b[5:0]};
					cont_left = cont_left - 3'd1;
					if (cont_left == 0) begin
						r.char_ready = 1'b1;
						r.code_point = partial_cp;
						partial_cp = '0;
						seen_multi = 1'b1;
						if (chars_in_buf != '1)
							chars_in_buf = chars_in_buf + 1'b1;
					end
				end
			end else if (!b[7]) begin
				if (is_plain_text(b)) begin
					r.char_ready = 1'b1;
					r.code_point = u8chk_pkg::CODE_POINT_W'(b);
					if (chars_in_buf != '1)
						chars_in_buf = chars_in_buf + 1'b1;
				end else begin
					buf_rejected = 1'b1;
				end
			end else if (!b[6]) begin
				buf_rejected = 1'b1;
			end else if (!b[5]) begin
				partial_cp = u8chk_pkg::CODE_POINT_W'(b[4:0]);
				cont_left = 3'd1;
			end else if (!b[4]) begin
				partial_cp = u8chk_pkg::CODE_POINT_W'(b[3:0]);
				cont_left = 3'd2;
			end else if (!b[3]) begin
				partial_cp = u8chk_pkg::CODE_POINT_W'(b[2:0]);
				cont_left = 3'd3;
			end else if (!b[2]) begin
				partial_cp = u8chk_pkg::CODE_POINT_W'(b[1:0]);
				cont_left = 3'd4;
			end else if (!b[1]) begin
				partial_cp = u8chk_pkg::CODE_POINT_W'(b[0]);
				cont_left = 3'd5;
			end else begin
				buf_rejected = 1'b1;
			end
		end
		r.char_count = chars_in_buf;
		r.verdict_ready = fin;
		r.is_utf8 = fin && !buf_rejected && seen_multi;
		if (fin) begin
			cont_left = '0;
			partial_cp = '0;
			seen_multi = 1'b0;
			buf_rejected = 1'b0;
			chars_in_buf = '0;
		end
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		if ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(decode_byte(b, fin));
		bytes_sent++;
	endtask

	task automatic send_buffer(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	function automatic logic [7:0] random_text_byte();
		int r;
		logic [7:0] ctrl[7];
		ctrl = '{8'h07, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h1B};
		r = $urandom_range(0, 101);
		if (r < 95)
			return 8'(8'h20 + r);
		return ctrl[r - 95];
	endfunction

	// Appends one well-formed sequence of n bytes with random payload bits.
	task automatic append_multibyte(ref byte_q_t q, input int n);
		logic [7:0] lead;
		lead = 8'hFF << (8 - n);
		q.push_back(lead | (8'($urandom) & ((8'd1 << (7 - n)) - 8'd1)));
		repeat (n - 1) q.push_back(8'h80 | 8'($urandom_range(0, 63)));
	endtask

	task automatic send_random_buffer();
		byte_q_t q;
		int n_chars;
		int noise_pct;
		int lead_len;
		n_chars = $urandom_range(1, 16);
		// Most buffers are clean text so that decoding reaches the final byte.
		noise_pct = ($urandom_range(99) < 75) ? 0 : $urandom_range(5, 30);
		repeat (n_chars) begin
			if ($urandom_range(99) < noise_pct)
				q.push_back(8'($urandom_range(0, 255)));
			else if ($urandom_range(99) < 45)
				q.push_back(random_text_byte());
			else
				append_multibyte(q, $urandom_range(2, 6));
		end
		// Now and then the buffer ends part way through a sequence.
		if ($urandom_range(99) < 10) begin
			lead_len = $urandom_range(2, 6);
			append_multibyte(q, lead_len);
			void'(q.pop_back());
		end
		send_buffer(q);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	task automatic test_well_formed();
		send_buffer('{8'h41, 8'hC3, 8'hA9, 8'h7E});
		send_buffer('{8'h20});
	endtask

	task automatic test_longest_sequence();
		send_buffer('{LEAD_SIX_BYTE, CONT_ALL_ONES, CONT_ALL_ONES, CONT_ALL_ONES,
			CONT_ALL_ONES, CONT_ALL_ONES});
	endtask

	task automatic test_rejections();
		send_buffer('{CONT_ALL_ZEROS});
		send_buffer('{LEAD_INVALID_FE, 8'h41});
		send_buffer('{LEAD_INVALID_FF});
		send_buffer('{8'hE2, 8'h41, 8'hC3, 8'hA9});
		send_buffer('{8'h00});
		send_buffer('{8'h0B});
	endtask

	task automatic test_truncation();
		send_buffer('{8'hC3, 8'hA9, 8'hF0, 8'h9F});
	endtask

	task automatic test_random_buffers(input int n_bytes);
		int stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_buffer();
	endtask

	// The output is held off while bytes keep coming, so the input queue fills.
	task automatic test_backpressure();
		hold_off_request = 1'b1;
		repeat (3) send_random_buffer();
		repeat (40) send_byte(random_text_byte(), 1'b0);
		send_buffer('{8'hE2, 8'h82, 8'hAC});
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			mismatches++;
			$error("%s: expected %0h, actual %0h", name, exp, act);
		end
	endtask

	// Receiver: random stalls, and one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_off_request) begin
			hold_off_request = 1'b0;
			idle_cycles = HOLD_OFF_CYCLES;
		end
		if (idle_cycles > 0) begin
			idle_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= receiver_stall_pct;
		end
	end

	always @(posedge clk) begin
		decode_result_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$error("result transfer with no result expected");
			end else begin
				exp = expected_results.pop_front();
				check_field("char_ready", 32'(exp.char_ready), 32'(char_ready));
				check_field("code_point", 32'(exp.code_point), 32'(code_point));
				check_field("char_count", 32'(exp.char_count), 32'(char_count));
				check_field("verdict_ready", 32'(exp.verdict_ready), 32'(verdict_ready));
				check_field("is_utf8", 32'(exp.is_utf8), 32'(is_utf8));
			end
		end
	end

	// Ends the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		int quiet_cycles;
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_gap_pct = 8;
		receiver_stall_pct = 85;
		test_well_formed();
		test_longest_sequence();
		test_rejections();
		test_truncation();
		test_random_buffers(620);

		sender_gap_pct = 85;
		receiver_stall_pct = 8;
		test_random_buffers(620);

		sender_gap_pct = 0;
		receiver_stall_pct = 0;
		test_random_buffers(620);
		test_backpressure();
		stop_sending();

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
